// ----- design/gc_pkg.sv -----
// gc_pkg: shared types for the golomb codec
// no dependencies
`timescale 1ns / 1ps

package gc_pkg;

  // datapath commands issued by the controller
  typedef struct packed {
    logic start_div;   // load dividend, begin long division
    logic div_step;    // one restoring division step
    logic load_chunk;  // build the next output chunk
    logic dec_bit;     // apply one code bit to the decoder state
    logic out_load;    // capture a result into the output register
  } gc_cmd_t;

  // datapath status reported to the controller
  typedef struct packed {
    logic div_last;    // current step is the final quotient bit
    logic enc_ovf;     // quotient exceeds the limit
    logic more_chunks; // bits remain after the chunk just built
    logic dec_done;    // the decode bit produced a result
  } gc_sts_t;

endpackage

// ----- design/gc_ctrl.sv -----
// gc_ctrl: sequencing state machine for the golomb codec
// depends on gc_pkg
`timescale 1ns / 1ps

module gc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_fire,
  input  logic           in_op,
  input  logic           out_free,
  input  gc_pkg::gc_sts_t sts,
  output logic           busy,
  output gc_pkg::gc_cmd_t cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DIV   = 2'd1;
  localparam logic [1:0] S_CHUNK = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign busy = (state != S_IDLE);

  // next state and command decode
  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (in_op) begin
            cmd.dec_bit = 1'b1;
          end else begin
            cmd.start_div = 1'b1;
            state_next = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_CHUNK;
      end
      S_CHUNK: begin
        if (out_free) begin
          cmd.load_chunk = 1'b1;
          cmd.out_load = 1'b1;
          if (sts.enc_ovf || !sts.more_chunks) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !cmd.dec_bit) else $error("decode while busy");
  a_div_leads: assert property (@(posedge clk) disable iff (rst)
    cmd.start_div |=> state == S_DIV) else $error("division not started");
  a_chunk_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.load_chunk |-> out_free) else $error("chunk into full output");
`endif

endmodule

// ----- design/gc_dp.sv -----
// gc_dp: division, chunk builder and bit decoder for the golomb codec
// depends on gc_pkg
`timescale 1ns / 1ps

module gc_dp #(
  parameter int MAX_QUOTIENT  = 1023,
  parameter int DIVISOR_WIDTH = 16,
  parameter int CHUNK_BITS    = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [DIVISOR_WIDTH-1:0] divisor,
  input  logic [31:0]              value,
  input  logic                     code_bit,
  input  gc_pkg::gc_cmd_t          cmd,
  output gc_pkg::gc_sts_t          sts,
  output logic [CHUNK_BITS-1:0]    res_chunk,
  output logic [5:0]               res_len,
  output logic                     res_last,
  output logic [31:0]              res_dec,
  output logic                     res_dvalid,
  output logic                     res_ovf
);

  localparam int QW = $clog2(MAX_QUOTIENT + 2) + 1;
  localparam int LW = $clog2(MAX_QUOTIENT + 2 + DIVISOR_WIDTH + 1) + 1;
  localparam int BW = $clog2(DIVISOR_WIDTH + 1);
  localparam int CLW = $clog2(CHUNK_BITS + 1);
  localparam int CIW = $clog2(CHUNK_BITS);
  localparam int QCW = $clog2(MAX_QUOTIENT + 1);

  // effective divisor and its truncated-binary parameters
  logic [DIVISOR_WIDTH-1:0] m;
  logic [BW-1:0]            b;
  logic [DIVISOR_WIDTH:0]   u;
  always_comb begin
    m = (divisor == '0) ? {{(DIVISOR_WIDTH-1){1'b0}}, 1'b1} : divisor;
    b = '0;
    for (int i = 0; i < DIVISOR_WIDTH; i++) begin
      if ((DIVISOR_WIDTH+1)'(1) << i < {1'b0, m}) b = BW'(i + 1);
    end
    u = ((DIVISOR_WIDTH+1)'(1) << b) - {1'b0, m};
  end

  // restoring divider, one quotient bit a cycle
  logic [31:0]              quo;
  logic [DIVISOR_WIDTH:0]   rem;
  logic [5:0]               step;
  logic [DIVISOR_WIDTH+1:0] trial;
  assign trial = {rem, quo[31]} - {1'b0, {1'b0, m}};
  assign sts.div_last = (step == 6'd31);

  // code layout
  logic [LW-1:0]         total;
  logic [LW-1:0]         pos;
  logic [QW-1:0]         q_len;
  logic [DIVISOR_WIDTH:0] tb_val;
  logic [BW-1:0]         tb_len;
  logic                  ovf;
  logic [CLW-1:0]        chunk_n;
  logic [CHUNK_BITS-1:0] chunk;
  logic [LW-1:0]         left;
  assign sts.enc_ovf = ovf;

  always_ff @(posedge clk) begin
    if (cmd.start_div) begin
      quo  <= value;
      rem  <= '0;
      step <= '0;
    end else if (cmd.div_step) begin
      step <= step + 6'd1;
      if (!trial[DIVISOR_WIDTH+1]) begin
        rem <= trial[DIVISOR_WIDTH:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= {rem[DIVISOR_WIDTH-1:0], quo[31]};
        quo <= {quo[30:0], 1'b0};
      end
      if (sts.div_last) begin
        // final remainder and quotient become the layout
        logic [DIVISOR_WIDTH:0] r;
        logic [31:0] qf;
        r  = trial[DIVISOR_WIDTH+1] ? {rem[DIVISOR_WIDTH-1:0], quo[31]}
                                    : trial[DIVISOR_WIDTH:0];
        qf = {quo[30:0], !trial[DIVISOR_WIDTH+1]};
        ovf <= (qf > 32'(MAX_QUOTIENT));
        q_len <= QW'(qf);
        pos <= '0;
        if (b == '0) begin
          tb_len <= '0;
          tb_val <= '0;
        end else if (r < u) begin
          tb_len <= b - BW'(1);
          tb_val <= r;
        end else begin
          tb_len <= b;
          tb_val <= r + u;
        end
        total <= LW'(qf[QW-1:0]) + LW'(1) +
                 (b == '0 ? LW'(0) : (r < u ? LW'(b) - LW'(1) : LW'(b)));
      end
    end else if (cmd.load_chunk) begin
      pos <= pos + LW'(chunk_n);
    end
  end

  // chunk builder: each bit position picks a unary, terminating zero or remainder bit
  always_comb begin
    logic [LW-1:0] p;
    logic [LW-1:0] k;
    logic [CIW-1:0] ix;
    left = total - pos;
    chunk_n = (left > LW'(CHUNK_BITS)) ? CLW'(CHUNK_BITS) : CLW'(left);
    chunk = '0;
    for (int i = 0; i < CHUNK_BITS; i++) begin
      p = pos + LW'(i);
      k = p - LW'(q_len) - LW'(1);
      ix = CIW'(chunk_n - CLW'(i) - CLW'(1));
      if (CLW'(i) < chunk_n) begin
        if (p < LW'(q_len)) chunk[ix] = 1'b1;
        else if (p > LW'(q_len))
          chunk[ix] = tb_val[BW'(LW'(tb_len) - LW'(1) - k)];
      end
    end
  end
  assign sts.more_chunks = (left > LW'(CHUNK_BITS));

  // decoder state
  logic [1:0]               phase;
  logic [QCW-1:0]           qcnt;
  logic [DIVISOR_WIDTH-1:0] racc;
  logic [4:0]               rbits;
  logic                     dec_done;
  logic                     dec_ovf;
  logic [31:0]              dec_val;
  logic [1:0]               phase_next;
  logic [QCW-1:0]           qcnt_next;
  logic [DIVISOR_WIDTH-1:0] racc_next;
  logic [4:0]               rbits_next;

  // one code bit: unary count, short remainder check or long remainder
  always_comb begin
    logic [DIVISOR_WIDTH-1:0] acc2;
    logic        chk;
    logic [31:0] rv;
    phase_next = (phase == 2'd3) ? 2'd0 : phase;
    qcnt_next = qcnt;
    racc_next = racc;
    rbits_next = rbits;
    dec_done = 1'b0;
    dec_ovf = 1'b0;
    chk = 1'b0;
    rv = '0;
    acc2 = {racc[DIVISOR_WIDTH-2:0], code_bit};
    if (phase == 2'd1) begin
      racc_next = acc2;
      rbits_next = rbits + 5'd1;
      chk = 1'b1;
    end else if (phase == 2'd2) begin
      // wraps when the divisor grew since the short part was read
      rv = 32'(acc2) - 32'(u);
      dec_done = 1'b1;
    end else if (code_bit) begin
      if (32'(qcnt) >= 32'(MAX_QUOTIENT)) dec_ovf = 1'b1;
      else qcnt_next = qcnt + QCW'(1);
    end else begin
      racc_next = '0;
      rbits_next = '0;
      chk = 1'b1;
    end
    if (chk) begin
      if (b == '0) begin
        dec_done = 1'b1;
      end else if (6'(rbits_next) + 6'd1 >= 6'(b)) begin
        if ({1'b0, racc_next} < u) begin
          dec_done = 1'b1;
          rv = 32'(racc_next);
        end else phase_next = 2'd2;
      end else phase_next = 2'd1;
    end
    dec_val = 32'(qcnt) * 32'(m) + rv;
    if (dec_done || dec_ovf) begin
      phase_next = '0;
      qcnt_next = '0;
      racc_next = '0;
      rbits_next = '0;
    end
  end
  assign sts.dec_done = dec_done || dec_ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      qcnt <= '0;
      racc <= '0;
      rbits <= '0;
    end else if (cmd.dec_bit) begin
      phase <= phase_next;
      qcnt <= qcnt_next;
      racc <= racc_next;
      rbits <= rbits_next;
    end
  end

  // result fields handed to the output register
  assign res_chunk  = (cmd.dec_bit || ovf) ? '0 : chunk;
  assign res_len    = cmd.dec_bit || ovf ? '0 : 6'(chunk_n);
  assign res_last   = cmd.dec_bit || ovf || !sts.more_chunks;
  assign res_dec    = (cmd.dec_bit && dec_done) ? dec_val : '0;
  assign res_dvalid = cmd.dec_bit && dec_done;
  assign res_ovf    = cmd.dec_bit ? dec_ovf : ovf;

`ifndef ASSERT_OFF
  a_phase_legal: assert property (@(posedge clk) disable iff (rst)
    cmd.dec_bit && sts.dec_done |=> phase == 2'd0 && qcnt == '0)
    else $error("decoder not cleared");
  a_qcnt_bound: assert property (@(posedge clk) disable iff (rst)
    32'(qcnt) <= 32'(MAX_QUOTIENT)) else $error("quotient count overrun");
  a_step_run: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step && !sts.div_last |=> step == $past(step) + 6'd1)
    else $error("division step lost");
`endif

endmodule

// ----- design/golomb_codec.sv -----
// golomb_codec: top level, configuration register, output register
// depends on gc_pkg, gc_ctrl, gc_dp
`timescale 1ns / 1ps

// Golomb coder/decoder with truncated-binary remainders. An encode transaction
// runs a restoring divider over all 32 quotient bits (one quotient bit a cycle),
// then emits one chunk per cycle as the output register frees; no new input is
// taken until it finishes. A decode transaction consumes one code bit and yields
// a result only when a codeword completes or the unary run overflows.
// Write divisor only when idle.
module golomb_codec #(
  parameter int MAX_QUOTIENT  = 1023,
  parameter int DIVISOR_WIDTH = 16,
  parameter int CHUNK_BITS    = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [DIVISOR_WIDTH-1:0] cfg_wdata,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [39:0]              s_tdata,  // value[31:0], code_bit[32]
  input  logic                     s_tuser,  // op
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [CHUNK_BITS+39:0]   m_tdata,  // chunk, chunk_len(6), dec value(32), valid
  output logic                     m_tuser,  // overflow
  output logic                     m_tlast   // last_chunk
);

  logic [DIVISOR_WIDTH-1:0] divisor;
  gc_pkg::gc_cmd_t cmd;
  gc_pkg::gc_sts_t sts;
  logic busy, in_fire, out_free;
  logic [CHUNK_BITS-1:0] r_chunk;
  logic [5:0]  r_len;
  logic [31:0] r_dec;
  logic r_last, r_dv, r_ovf;

  // divisor register
  always_ff @(posedge clk) begin
    if (rst) divisor <= DIVISOR_WIDTH'(1);
    else if (cfg_we) divisor <= cfg_wdata;
  end

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = !busy && out_free;
  assign in_fire  = s_tvalid && s_tready;

  gc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .in_op(s_tuser),
    .out_free(out_free), .sts(sts), .busy(busy), .cmd(cmd)
  );

  gc_dp #(
    .MAX_QUOTIENT(MAX_QUOTIENT), .DIVISOR_WIDTH(DIVISOR_WIDTH),
    .CHUNK_BITS(CHUNK_BITS)
  ) u_dp (
    .clk(clk), .rst(rst), .divisor(divisor), .value(s_tdata[31:0]),
    .code_bit(s_tdata[32]), .cmd(cmd), .sts(sts), .res_chunk(r_chunk),
    .res_len(r_len), .res_last(r_last), .res_dec(r_dec), .res_dvalid(r_dv),
    .res_ovf(r_ovf)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load || (cmd.dec_bit && sts.dec_done)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load || (cmd.dec_bit && sts.dec_done)) begin
      m_tdata <= {1'b0, r_dv, r_dec, r_len, r_chunk};
      m_tuser <= r_ovf;
      m_tlast <= r_last;
    end
  end

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
  a_idle_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> !busy) else $error("accept while busy");
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[CHUNK_BITS+5:CHUNK_BITS] <= 6'(CHUNK_BITS))
    else $error("chunk length too large");
`endif

endmodule

// ----- tb/sv/golomb_codec_tb.sv -----
// golomb_codec_tb: self-checking testbench for the golomb codec
// depends on golomb_codec; predicts encode chunks and decoded values
`timescale 1ns / 1ps

module golomb_codec_tb;

  localparam int MAX_Q     = 1023;
  localparam int CHUNK_W   = 32;
  localparam int OP_ENCODE = 0;
  localparam int OP_DECODE = 1;
  localparam int PH_UNARY  = 0;
  localparam int PH_SHORT  = 1;
  localparam int PH_EXTRA  = 2;
  localparam int LIMIT     = 2000000;

  typedef struct packed {
    logic        op;
    logic [31:0] value;
    logic        code_bit;
  } item_t;

  typedef struct packed {
    logic [31:0] chunk;
    logic [5:0]  len;
    logic        last;
    logic [31:0] dval;
    logic        dvalid;
    logic        ovf;
  } res_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [15:0] cfg_wdata = '0;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        s_tuser = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [71:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  golomb_codec u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // predictor state
  logic [15:0] div_reg = 16'd1;
  int unsigned ph, qcnt, racc, rbits;
  item_t pending_q[$];
  res_t  expected_q[$];
  int    errors = 0;
  bit    hold_long = 0;

  function automatic int unsigned eff_m();
    return (div_reg == 0) ? 1 : div_reg;
  endfunction

  function automatic int unsigned clog2_of(int unsigned m);
    int unsigned b;
    b = 0;
    while (b < 32 && (64'd1 << b) < m) b++;
    return b;
  endfunction

  function automatic res_t decoded_res(int unsigned r);
    res_t x;
    x = '0;
    x.last = 1;
    x.dvalid = 1;
    x.dval = 32'(64'(qcnt) * eff_m() + r);
    ph = PH_UNARY; qcnt = 0; racc = 0; rbits = 0;
    return x;
  endfunction

  // after the first b-1 remainder bits: finish short or wait one more bit
  function automatic void after_short();
    int unsigned m, b, u;
    m = eff_m(); b = clog2_of(m); u = (1 << b) - m;
    if (b == 0) expected_q.push_back(decoded_res(0));
    else if (rbits + 1 >= b) begin
      if (racc < u) expected_q.push_back(decoded_res(racc));
      else ph = PH_EXTRA;
    end else ph = PH_SHORT;
  endfunction

  function automatic void predict_codec(item_t it);
    int unsigned m, b, u, q, r, len, v, total, pos, n;
    logic [31:0] chunk;
    res_t x;
    m = eff_m(); b = clog2_of(m); u = (1 << b) - m;
    if (ph > PH_EXTRA) ph = PH_UNARY;
    if (it.op == OP_DECODE) begin
      if (ph == PH_SHORT) begin
        racc = ((racc << 1) | it.code_bit) & 16'hFFFF;
        rbits = (rbits + 1) & 31;
        after_short();
      end else if (ph == PH_EXTRA) begin
        expected_q.push_back(decoded_res(((racc << 1) | it.code_bit) - u));
      end else if (it.code_bit) begin
        if (qcnt >= MAX_Q) begin
          x = '0; x.last = 1; x.ovf = 1;
          expected_q.push_back(x);
          ph = PH_UNARY; qcnt = 0; racc = 0; rbits = 0;
        end else qcnt++;
      end else begin
        racc = 0; rbits = 0;
        after_short();
      end
      return;
    end
    q = it.value / m;
    r = it.value - q * m;
    if (q > MAX_Q) begin
      x = '0; x.last = 1; x.ovf = 1;
      expected_q.push_back(x);
      return;
    end
    if (b == 0) begin len = 0; v = 0; end
    else if (r < u) begin len = b - 1; v = r; end
    else begin len = b; v = r + u; end
    total = q + 1 + len;
    pos = 0;
    while (pos < total) begin
      n = (total - pos > CHUNK_W) ? CHUNK_W : total - pos;
      chunk = '0;
      for (int k = 0; k < n; k++) begin
        if (pos < q) chunk = {chunk[30:0], 1'b1};
        else if (pos == q) chunk = {chunk[30:0], 1'b0};
        else chunk = {chunk[30:0], 1'(v >> (len - 1 - (pos - q - 1)))};
        pos++;
      end
      x = '0; x.chunk = chunk; x.len = 6'(n); x.last = (pos >= total);
      expected_q.push_back(x);
    end
  endfunction

  // random gap: mostly short, a few long
  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // driver
  int unsigned src_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict_codec({s_tuser, s_tdata[31:0], s_tdata[32]});
        src_gap = gap_len();
      end
      if (!(s_tvalid && !s_tready)) begin
        if (src_gap > 0 || pending_q.size() == 0) begin
          s_tvalid <= 0;
          if (src_gap > 0) src_gap--;
        end else begin
          item_t it;
          it = pending_q.pop_front();
          s_tvalid <= 1;
          s_tuser <= it.op;
          s_tdata <= {7'd0, it.code_bit, it.value};
        end
      end
    end
  end

  // monitor and receiver stalls
  int unsigned dst_gap = 0;
  int unsigned hold_cnt = 0;
  always @(posedge clk) begin
    res_t got, want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = {m_tdata[31:0], m_tdata[37:32], m_tlast, m_tdata[69:38], m_tdata[70], m_tuser};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $realtime, got);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected chunk=%h len=%0d last=%0d val=%h dv=%0d ovf=%0d",
                     $realtime, want.chunk, want.len, want.last, want.dval, want.dvalid, want.ovf);
            $display("%0t:          actual chunk=%h len=%0d last=%0d val=%h dv=%0d ovf=%0d",
                     $realtime, got.chunk, got.len, got.last, got.dval, got.dvalid, got.ovf);
            errors++;
          end
        end
      end
      if (hold_long) begin
        hold_cnt++;
        m_tready <= (hold_cnt > 300);
      end else if (dst_gap > 0) begin
        dst_gap--;
        m_tready <= 0;
      end else begin
        m_tready <= 1;
        dst_gap = gap_len();
      end
    end
  end

  // cycle limit
  int unsigned cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic push_enc(logic [31:0] v);
    pending_q.push_back('{op: OP_ENCODE, value: v, code_bit: $urandom_range(0, 1)});
  endtask

  task automatic push_dec(bit cb);
    pending_q.push_back('{op: OP_DECODE, value: $urandom, code_bit: cb});
  endtask

  // encode a value and feed its codeword back bit by bit
  task automatic push_roundtrip(logic [31:0] v);
    int unsigned m, b, u, q, r, len, w;
    m = (div_reg == 0) ? 1 : div_reg; b = clog2_of(m); u = (1 << b) - m;
    q = v / m; r = v - q * m;
    push_enc(v);
    if (q > MAX_Q) return;
    if (b == 0) begin len = 0; w = 0; end
    else if (r < u) begin len = b - 1; w = r; end
    else begin len = b; w = r + u; end
    repeat (q) push_dec(1);
    push_dec(0);
    for (int k = len - 1; k >= 0; k--) push_dec((w >> k) & 1);
  endtask

  task automatic drain();
    wait (pending_q.size() == 0 && !s_tvalid);
    wait (expected_q.size() == 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_divisor(logic [15:0] d);
    @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= d;
    div_reg = d;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  initial begin
    logic [15:0] divs[8];
    logic [15:0] m;
    divs = '{16'd0, 16'd1, 16'd5, 16'd8, 16'd3, 16'd65535, 16'd37, 16'd32768};
    ph = PH_UNARY; qcnt = 0; racc = 0; rbits = 0;
    repeat (3) @(posedge clk);
    rst <= 0;

    // directed: reset divisor, extremes, overflow, long unary run
    push_enc(0); push_enc(1); push_enc(1023); push_enc(1024); push_enc(32'hFFFF_FFFF);
    push_enc(40); push_enc(100);
    push_roundtrip(5); push_roundtrip(0);
    drain();
    set_divisor(16'd5);
    for (int i = 0; i < 5; i++) push_roundtrip(i);
    push_enc(5 * 1023 + 4); push_enc(5 * 1024);
    push_enc(32'hFFFF_FFFF);
    drain();

    // random phases over several divisors, one with a long receiver hold-off
    foreach (divs[d]) begin
      set_divisor(divs[d]);
      m = (divs[d] == 0) ? 1 : divs[d];
      if (d == 3) begin
        push_enc(32'd40); push_enc(32'd300); push_enc(32'd9);
      end
      for (int i = 0; i < 6; i++) begin
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 50) push_roundtrip(32'($urandom_range(0, 4)) * m + $urandom_range(0, m - 1));
        else if (p < 65) push_enc($urandom);
        else if (p < 75) push_enc(32'($urandom_range(0, 200)) * m + $urandom_range(0, m - 1));
        else push_dec($urandom_range(0, 1));
      end
      if (d == 3) begin
        hold_long = 1;
        wait (pending_q.size() == 0);
        hold_long = 0;
      end
      // a few zeros to walk the short and extra remainder paths
      repeat (4) push_dec(0);
      drain();
    end

    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
